### sv/rce_pkg.sv
// rce_pkg: shared types, codes and constants of the tristate remote code encoder.
// No dependencies; imported by rce_frame_seq, tristate_remote_code_encoder and the verif files.
`timescale 1ns / 1ps

package rce_pkg;

    // Word geometry
    localparam int WORD_BITS = 12;
    localparam int POS_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    // Field widths
    localparam int REPEATS_W = 4;
    localparam int GAP_W     = 6;
    localparam int SENT_W    = 3;
    localparam int UNIT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 6;

    // Words per frame are clamped to this range
    localparam logic [REPEATS_W-1:0] REPEATS_MIN = REPEATS_W'(1);
    localparam logic [REPEATS_W-1:0] REPEATS_MAX = REPEATS_W'(8);

    // Register reset values
    localparam logic [REPEATS_W-1:0] REPEATS_RESET = REPEATS_W'(4);
    localparam logic [GAP_W-1:0]     GAP_RESET     = GAP_W'(31);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_REPEATS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GAP_UNITS = 1'b1;

    // Input item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // Units inside one bit cell (eight units per bit)
    localparam logic [UNIT_W-1:0] UNIT_FIRST_HIGH  = UNIT_W'(0);
    localparam logic [UNIT_W-1:0] UNIT_SECOND_HIGH = UNIT_W'(4);
    localparam logic [UNIT_W-1:0] UNIT_FLOAT_A     = UNIT_W'(5);
    localparam logic [UNIT_W-1:0] UNIT_FLOAT_B     = UNIT_W'(6);
    localparam logic [UNIT_W-1:0] UNIT_LAST        = UNIT_W'(7);

    typedef struct packed {
        logic [REPEATS_W-1:0] word_repeats;
        logic [GAP_W-1:0]     sync_gap_units;
    } t_cfg;

    typedef struct packed {
        logic                 func;
        logic [WORD_BITS-1:0] data_word;
    } t_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_result;

endpackage

### sv/rce_frame_seq.sv
// rce_frame_seq: frame sequencer of the tristate remote code encoder.
// Holds the frame state and turns one item into one result. Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_frame_seq import rce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [WORD_BITS-1:0] r_word, n_word;
    logic [SENT_W-1:0]    r_sent, n_sent;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [UNIT_W-1:0]    r_unit, n_unit;
    logic [GAP_W-1:0]     r_sync, n_sync;
    logic                 r_in_sync, n_in_sync;
    logic                 r_active, n_active;

    logic [REPEATS_W-1:0] eff_repeats;
    logic [POS_W-1:0]     bit_idx;
    logic                 cur_bit;
    logic                 last_word;

    // clamp words per frame to 1..8
    always_comb begin
        if (i_cfg.word_repeats == '0) begin
            eff_repeats = REPEATS_MIN;
        end else if (i_cfg.word_repeats > REPEATS_MAX) begin
            eff_repeats = REPEATS_MAX;
        end else begin
            eff_repeats = i_cfg.word_repeats;
        end
    end

    assign bit_idx   = POS_W'(WORD_BITS - 1) - r_pos;
    assign cur_bit   = r_word[bit_idx];
    assign last_word = (REPEATS_W'(r_sent) + REPEATS_W'(1)) >= eff_repeats;

    always_comb begin
        n_word    = r_word;
        n_sent    = r_sent;
        n_pos     = r_pos;
        n_unit    = r_unit;
        n_sync    = r_sync;
        n_in_sync = r_in_sync;
        n_active  = r_active;
        o_result  = '0;

        if (i_item.func == FUNC_START) begin
            if (!r_active) begin
                n_word    = i_item.data_word;
                n_sent    = '0;
                n_pos     = '0;
                n_unit    = '0;
                n_sync    = '0;
                n_in_sync = 1'b0;
                n_active  = 1'b1;
            end
            o_result.busy_res = 1'b1;
        end else if (r_active) begin
            o_result.busy_res = 1'b1;
            if (!r_in_sync) begin
                o_result.line_level = (r_unit == UNIT_FIRST_HIGH) ||
                                      (r_unit == UNIT_SECOND_HIGH) ||
                                      (!cur_bit && ((r_unit == UNIT_FLOAT_A) ||
                                                    (r_unit == UNIT_FLOAT_B)));
                n_unit = r_unit + UNIT_W'(1);
                if (r_unit == UNIT_LAST) begin
                    if (r_pos == POS_W'(WORD_BITS - 1)) begin
                        n_pos     = '0;
                        n_in_sync = 1'b1;
                        n_sync    = '0;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end else begin
                o_result.line_level = (r_sync == '0);
                if (r_sync >= i_cfg.sync_gap_units) begin
                    n_in_sync = 1'b0;
                    n_sync    = '0;
                    if (last_word) begin
                        n_active            = 1'b0;
                        o_result.frame_done = 1'b1;
                        n_word              = '0;
                        n_sent              = '0;
                    end else begin
                        n_sent = r_sent + SENT_W'(1);
                    end
                end else begin
                    n_sync = r_sync + GAP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word    <= '0;
            r_sent    <= '0;
            r_pos     <= '0;
            r_unit    <= '0;
            r_sync    <= '0;
            r_in_sync <= 1'b0;
            r_active  <= 1'b0;
        end else if (i_step) begin
            r_word    <= n_word;
            r_sent    <= n_sent;
            r_pos     <= n_pos;
            r_unit    <= n_unit;
            r_sync    <= n_sync;
            r_in_sync <= n_in_sync;
            r_active  <= n_active;
        end
    end

`ifndef SYNTHESIS
    a_done_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.frame_done |=> !r_active)
        else $error("frame still active after its last unit");

    a_idle_tick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active && i_item.func == FUNC_TICK |-> o_result == '0)
        else $error("tick while idle produced a nonzero result");

    a_sync_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_sync || r_unit != '0 |-> r_active)
        else $error("sync or bit cell progress outside a frame");
`endif

endmodule

### sv/tristate_remote_code_encoder.sv
// tristate_remote_code_encoder: top level with input stage, result stage and config.
// Depends on rce_pkg and rce_frame_seq.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_word; tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: line_level; tuser: busy_res;
//                                             tlast: frame_done
// cfg       in   i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while m_axis does not stall; each item yields one
// result via the input register, then the result register. The frame sequencer
// updates its state in the same cycle the item moves into the result register.
// Reset is synchronous, active low, and returns the block to idle with the
// default configuration. A stall on m_axis holds both stages; the input register
// still takes a transfer while the result register waits if it is itself free.

module tristate_remote_code_encoder import rce_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [11:0] data_word, [15:12] zero
    input  logic                  s_axis_tuser,   // [0] func
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [0] line_level, [7:1] zero
    output logic                  m_axis_tuser,   // [0] busy_res
    output logic                  m_axis_tlast,   // frame_done
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;

    t_result seq_result;
    logic    advance;

    // move the held item on when the result register is free or being drained
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // configuration registers, written directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.word_repeats   <= REPEATS_RESET;
            r_cfg.sync_gap_units <= GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WORD_REPEATS:   r_cfg.word_repeats   <= i_cfg_data[REPEATS_W-1:0];
                CFG_SYNC_GAP_UNITS: r_cfg.sync_gap_units <= i_cfg_data[GAP_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // input register: capture on transfer, drop the valid once forwarded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.func      <= s_axis_tuser;
            r_item.data_word <= s_axis_tdata[WORD_BITS-1:0];
        end
    end

    rce_frame_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && advance),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (seq_result)
    );

    // result register: load when the held item advances, clear valid on drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out <= seq_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out.line_level};
    assign m_axis_tuser  = r_out.busy_res;
    assign m_axis_tlast  = r_out.frame_done;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled while result register is empty");

    a_item_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance |=> m_axis_tvalid)
        else $error("forwarded item did not produce a result");

    a_done_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser && m_axis_tdata[7:1] == '0)
        else $error("frame end result without busy flag");
`endif

endmodule

### verif/rce_unit_checker.sv
// rce_unit_checker: scoreboard for the tristate remote code encoder streams.
// Predicts one line unit per input transfer and compares result transfers in order.
// Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_unit_checker import rce_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [15:0]           i_s_tdata,   // [11:0] data_word, [15:12] zero
    input  logic                  i_s_tuser,   // [0] func
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [7:0]            i_m_tdata,   // [0] line_level, [7:1] zero
    input  logic                  i_m_tuser,   // [0] busy_res
    input  logic                  i_m_tlast,   // frame_done
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    // Shadow configuration
    logic [REPEATS_W-1:0] repeats_reg;
    logic [GAP_W-1:0]     gap_reg;

    // Shadow frame state
    logic [WORD_BITS-1:0] shift_word;
    logic [SENT_W-1:0]    words_sent;
    logic [POS_W-1:0]     bit_pos;
    logic [UNIT_W-1:0]    unit_in_bit;
    logic [GAP_W-1:0]     sync_count;
    logic                 in_sync;
    logic                 sending;

    t_result expected_units[$];
    int      mismatch_count = 0;

    // Advance the shadow encoder by one input item and return the unit it yields.
    function automatic t_result encode_unit(input logic func, input logic [WORD_BITS-1:0] word);
        t_result              r;
        logic                 cell_bit;
        logic [UNIT_W-1:0]    unit;
        logic [REPEATS_W-1:0] words_per_frame;
        r = '0;
        if (repeats_reg < REPEATS_MIN)
            words_per_frame = REPEATS_MIN;
        else if (repeats_reg > REPEATS_MAX)
            words_per_frame = REPEATS_MAX;
        else
            words_per_frame = repeats_reg;

        if (func == FUNC_START) begin
            // a start only loads when idle; a start while busy is dropped
            if (!sending) begin
                shift_word  = word;
                words_sent  = '0;
                bit_pos     = '0;
                unit_in_bit = '0;
                sync_count  = '0;
                in_sync     = 1'b0;
                sending     = 1'b1;
            end
            r.busy_res = 1'b1;
        end else if (sending) begin
            r.busy_res = 1'b1;
            if (!in_sync) begin
                cell_bit = shift_word[WORD_BITS-1-bit_pos];
                unit     = unit_in_bit;
                r.line_level = (unit == UNIT_FIRST_HIGH) || (unit == UNIT_SECOND_HIGH) ||
                               (!cell_bit && (unit == UNIT_FLOAT_A || unit == UNIT_FLOAT_B));
                unit_in_bit = unit + 1'b1;
                if (unit == UNIT_LAST) begin
                    if (bit_pos == POS_W'(WORD_BITS-1)) begin
                        bit_pos    = '0;
                        in_sync    = 1'b1;
                        sync_count = '0;
                    end else begin
                        bit_pos = bit_pos + 1'b1;
                    end
                end
            end else begin
                r.line_level = (sync_count == '0);
                if (sync_count >= gap_reg) begin
                    in_sync    = 1'b0;
                    sync_count = '0;
                    if (int'(words_sent) + 1 >= int'(words_per_frame)) begin
                        sending      = 1'b0;
                        r.frame_done = 1'b1;
                        shift_word   = '0;
                        words_sent   = '0;
                    end else begin
                        words_sent = words_sent + 1'b1;
                    end
                end else begin
                    sync_count = sync_count + 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic flag_field(input string field, input logic want, input logic got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %b, actual %b", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            repeats_reg = REPEATS_RESET;
            gap_reg     = GAP_RESET;
            shift_word  = '0;
            words_sent  = '0;
            bit_pos     = '0;
            unit_in_bit = '0;
            sync_count  = '0;
            in_sync     = 1'b0;
            sending     = 1'b0;
            expected_units.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WORD_REPEATS)
                    repeats_reg = i_cfg_data[REPEATS_W-1:0];
                else if (i_cfg_idx == CFG_SYNC_GAP_UNITS)
                    gap_reg = i_cfg_data[GAP_W-1:0];
            end
            // a result transfer at this edge belongs to an earlier input
            if (i_m_tvalid && i_m_tready) begin
                got = '{line_level: i_m_tdata[0], busy_res: i_m_tuser, frame_done: i_m_tlast};
                if (expected_units.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected: expected none, actual %b",
                             $time, got);
                end else begin
                    want = expected_units.pop_front();
                    flag_field("line_level", want.line_level, got.line_level);
                    flag_field("busy_res", want.busy_res, got.busy_res);
                    flag_field("frame_done", want.frame_done, got.frame_done);
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_units.push_back(encode_unit(i_s_tuser, i_s_tdata[WORD_BITS-1:0]));
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_units.size();
    end

endmodule

### verif/tristate_remote_code_encoder_test.sv
// tristate_remote_code_encoder_test: stimulus and verdict for the remote code encoder.
// Depends on rce_pkg, rce_unit_checker and the tristate_remote_code_encoder RTL.
`timescale 1ns / 1ps

module tristate_remote_code_encoder_test import rce_pkg::*;;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;     // [11:0] data_word, [15:12] zero
    logic                  s_axis_tuser = 1'b0;   // [0] func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;          // [0] line_level, [7:1] zero
    logic                  m_axis_tuser;          // [0] busy_res
    logic                  m_axis_tlast;          // frame_done
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int   mismatches;
    int   outstanding;
    int   cycles = 0;
    logic quiet = 1'b0;     // set for the closing stretch: no stalls, no gaps
    int   calm_items = 0;   // sender items left in a gap-free stretch
    int   stall_left = 0;   // receiver low cycles left in the current burst
    int   steady_left = 0;  // receiver cycles left in a stall-free stretch

    tristate_remote_code_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    rce_unit_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .i_m_tlast     (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it hangs anywhere.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** tristate_remote_code_encoder: FAILED **");
            $finish;
        end
    end

    // Result side: drop tready in random bursts, with stall-free stretches in
    // between; hold it high in the closing stretch.
    always @(posedge i_clk) begin
        if (steady_left != 0)
            steady_left <= steady_left - 1;
        else if ($urandom_range(0, 59) == 0)
            steady_left <= $urandom_range(30, 90);

        if (stall_left > 1) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && steady_left == 0 && $urandom_range(0, 9) == 0) begin
            stall_left    <= $urandom_range(1, 17);
            m_axis_tready <= 1'b0;
        end else begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one item and hold it until the transfer; maybe open a gap first.
    task automatic send_item(input logic func, input logic [WORD_BITS-1:0] word);
        int gap;
        gap = 0;
        if (calm_items != 0)
            calm_items--;
        else if ($urandom_range(0, 39) == 0)
            calm_items = $urandom_range(20, 60);
        else if (!quiet && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 17);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(16-WORD_BITS){1'b0}}, word};
        s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every expected unit has come back,
    // then let the two-stage pipeline sit idle before going on.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back cycles; the enable stays high across them.
    task automatic program_config(input logic [REPEATS_W-1:0] repeats,
                                  input logic [GAP_W-1:0] gap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WORD_REPEATS;
        i_cfg_data <= CFG_DATA_W'(repeats);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SYNC_GAP_UNITS;
        i_cfg_data <= CFG_DATA_W'(gap);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly ticks with a start now and then: starts while idle open a frame,
    // starts while busy are dropped by the block. Ticks carry random noise data.
    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            if (!quiet && $urandom_range(0, 199) == 0)
                settle();
            send_item(($urandom_range(0, 11) == 0) ? FUNC_START : FUNC_TICK,
                      WORD_BITS'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ticks while idle, a start with all bits set, a start while
        // busy (dropped), then the first bit cells of the frame.
        send_item(FUNC_TICK, '1);
        send_item(FUNC_TICK, '0);
        send_item(FUNC_START, '1);
        send_item(FUNC_START, '0);
        for (int k = 0; k < 20; k++)
            send_item(FUNC_TICK, WORD_BITS'($urandom));

        // Default configuration: four words, 31 gap units.
        send_random(250);

        // One word, sync reduced to its high unit; likely lands mid-frame.
        settle();
        program_config(REPEATS_W'(1), GAP_W'(0));
        send_random(200);

        // Largest legal word count and the longest gap.
        settle();
        program_config(REPEATS_MAX, GAP_W'(63));
        send_random(250);

        // Zero repeats behaves as one.
        settle();
        program_config(REPEATS_W'(0), GAP_W'(1));
        send_random(150);

        // Repeats above eight clamp to eight.
        settle();
        program_config(REPEATS_W'(15), GAP_W'(2));
        send_random(150);

        // Closing mix, last stretch with no idling on either side.
        settle();
        program_config(REPEATS_W'(2), GAP_W'(7));
        send_random(180);
        quiet <= 1'b1;
        send_random(150);

        settle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** tristate_remote_code_encoder: PASSED **");
        end else begin
            $display("** tristate_remote_code_encoder: FAILED **");
        end
        $finish;
    end

endmodule
